// ----- rtl/core/utilization_event_accumulator_macros.svh -----
// assertion macros used by the utilization event accumulator sequencer
`ifndef UTILIZATION_EVENT_ACCUMULATOR_MACROS_SVH
`define UTILIZATION_EVENT_ACCUMULATOR_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define UEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uea: same-cycle check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define UEA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uea: next-cycle check failed");

`endif

// ----- rtl/core/uea_pkg.sv -----
// shared types, constants and microcode store of the utilization event accumulator
`timescale 1ns / 1ps

package uea_pkg;

  localparam int unsigned TOT_W      = 64;
  localparam int unsigned RATE_W     = 40;
  localparam int unsigned CORES_W    = 11;
  localparam int unsigned AMT_W      = 32;
  localparam int unsigned IVL_W      = 40;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned PCT_W      = 14;
  localparam int unsigned NRES       = 5;
  localparam int unsigned RIDX_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  // datapath widths
  localparam int unsigned MUL_W = 108;
  localparam int unsigned MB_W  = 44;
  localparam int unsigned DEN_W = 80;
  localparam int unsigned QUO_W = 15;
  localparam int unsigned DSH_W = DEN_W + QUO_W - 1;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned PC_W  = 6;

  localparam logic [RATE_W-1:0] DEFAULT_LINE_RATE = 40'd125000000;
  localparam logic [MB_W-1:0]   NS_PCT_SCALE      = 44'd10000000000000;
  localparam logic [PCT_W-1:0]  PCT_FULL          = 14'd10000;

  // multiplier bits walked per operand, quotient bits per division
  localparam logic [CNT_W-1:0] CNT_NONE  = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_RATE  = CNT_W'(RATE_W);
  localparam logic [CNT_W-1:0] CNT_CORES = CNT_W'(CORES_W);
  localparam logic [CNT_W-1:0] CNT_SCALE = CNT_W'(MB_W);
  localparam logic [CNT_W-1:0] CNT_PCT   = CNT_W'(PCT_W);
  localparam logic [CNT_W-1:0] CNT_DIV   = CNT_W'(QUO_W);

  localparam logic [RIDX_W-1:0] RES_NET_TPUT  = 3'd0;
  localparam logic [RIDX_W-1:0] RES_NET_STACK = 3'd1;
  localparam logic [RIDX_W-1:0] RES_DISK      = 3'd2;
  localparam logic [RIDX_W-1:0] RES_CPU       = 3'd3;
  localparam logic [RIDX_W-1:0] RES_CACHE     = 3'd4;

  localparam logic [PC_W-1:0] PC_IDLE = 6'd0;
  localparam logic [PC_W-1:0] PC_EMIT = 6'd36;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NIC_LINE_RATE = 2'd0,
    REG_CORE_COUNT    = 2'd1
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX_BYTES = 3'd0,
    KIND_RX_BYTES = 3'd1,
    KIND_TX_LAT   = 3'd2,
    KIND_RX_LAT   = 3'd3,
    KIND_BLOCK    = 3'd4,
    KIND_SCHED    = 3'd5,
    KIND_CACHE    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL,
    OP_MVD,
    OP_DIV,
    OP_STO,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_LOOP,
    J_WAIT_START,
    J_WAIT_OUT
  } jmp_e;

  typedef enum logic [2:0] {
    A_NET_BYTE,
    A_NET_LAT,
    A_DISK,
    A_CPU,
    A_CACHE_MISS,
    A_CACHE_REF,
    A_IVL
  } asel_e;

  typedef enum logic [2:0] {
    B_NS_PCT,
    B_PCT_FULL,
    B_RATE,
    B_CORES,
    B_ONE
  } bsel_e;

  typedef struct packed {
    op_e               op;
    jmp_e              jmp;
    asel_e             a_sel;
    bsel_e             b_sel;
    logic [CNT_W-1:0]  cnt;
    logic [RIDX_W-1:0] ridx;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic [TOT_W-1:0] net_byte;
    logic [TOT_W-1:0] net_lat;
    logic [TOT_W-1:0] disk;
    logic [TOT_W-1:0] cpu;
    logic [TOT_W-1:0] cache_ref;
    logic [TOT_W-1:0] cache_miss;
  } totals_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [CORES_W-1:0] cores;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{rate: '0, cores: 11'd1};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [AMT_W-1:0]  amount;
    logic [AMT_W-1:0]  svc;
    logic              is_miss;
  } event_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } seq_stat_t;

  typedef logic [NRES-1:0][PCT_W-1:0] res_t;

  function automatic uword_t mk_uword(op_e op, jmp_e jmp, asel_e a_sel, bsel_e b_sel,
                                      logic [CNT_W-1:0] cnt, logic [RIDX_W-1:0] ridx,
                                      logic [PC_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.jmp    = jmp;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.cnt    = cnt;
    w.ridx   = ridx;
    w.target = target;
    return w;
  endfunction

  // cnt is loaded into the step counter when a step hands over to the next one
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      6'd0:  w = mk_uword(OP_IDLE, J_WAIT_START, A_IVL, B_ONE, CNT_NONE, '0, PC_IDLE);
      // throughput: bytes * 1e13 / (interval * line rate)
      6'd1:  w = mk_uword(OP_LOAD, J_NEXT, A_IVL, B_RATE, CNT_RATE, '0, PC_IDLE);
      6'd2:  w = mk_uword(OP_MUL, J_LOOP, A_IVL, B_RATE, CNT_NONE, '0, 6'd2);
      6'd3:  w = mk_uword(OP_MVD, J_NEXT, A_IVL, B_RATE, CNT_NONE, '0, PC_IDLE);
      6'd4:  w = mk_uword(OP_LOAD, J_NEXT, A_NET_BYTE, B_NS_PCT, CNT_SCALE, '0, PC_IDLE);
      6'd5:  w = mk_uword(OP_MUL, J_LOOP, A_NET_BYTE, B_NS_PCT, CNT_DIV, '0, 6'd5);
      6'd6:  w = mk_uword(OP_DIV, J_LOOP, A_NET_BYTE, B_NS_PCT, CNT_NONE, '0, 6'd6);
      6'd7:  w = mk_uword(OP_STO, J_NEXT, A_NET_BYTE, B_NS_PCT, CNT_NONE, RES_NET_TPUT,
                          PC_IDLE);
      // stack latency over interval
      6'd8:  w = mk_uword(OP_LOAD, J_NEXT, A_IVL, B_ONE, CNT_ONE, '0, PC_IDLE);
      6'd9:  w = mk_uword(OP_MUL, J_LOOP, A_IVL, B_ONE, CNT_NONE, '0, 6'd9);
      6'd10: w = mk_uword(OP_MVD, J_NEXT, A_IVL, B_ONE, CNT_NONE, '0, PC_IDLE);
      6'd11: w = mk_uword(OP_LOAD, J_NEXT, A_NET_LAT, B_PCT_FULL, CNT_PCT, '0, PC_IDLE);
      6'd12: w = mk_uword(OP_MUL, J_LOOP, A_NET_LAT, B_PCT_FULL, CNT_DIV, '0, 6'd12);
      6'd13: w = mk_uword(OP_DIV, J_LOOP, A_NET_LAT, B_PCT_FULL, CNT_NONE, '0, 6'd13);
      6'd14: w = mk_uword(OP_STO, J_NEXT, A_NET_LAT, B_PCT_FULL, CNT_NONE, RES_NET_STACK,
                          PC_IDLE);
      // disk service time over interval
      6'd15: w = mk_uword(OP_LOAD, J_NEXT, A_IVL, B_ONE, CNT_ONE, '0, PC_IDLE);
      6'd16: w = mk_uword(OP_MUL, J_LOOP, A_IVL, B_ONE, CNT_NONE, '0, 6'd16);
      6'd17: w = mk_uword(OP_MVD, J_NEXT, A_IVL, B_ONE, CNT_NONE, '0, PC_IDLE);
      6'd18: w = mk_uword(OP_LOAD, J_NEXT, A_DISK, B_PCT_FULL, CNT_PCT, '0, PC_IDLE);
      6'd19: w = mk_uword(OP_MUL, J_LOOP, A_DISK, B_PCT_FULL, CNT_DIV, '0, 6'd19);
      6'd20: w = mk_uword(OP_DIV, J_LOOP, A_DISK, B_PCT_FULL, CNT_NONE, '0, 6'd20);
      6'd21: w = mk_uword(OP_STO, J_NEXT, A_DISK, B_PCT_FULL, CNT_NONE, RES_DISK, PC_IDLE);
      // on-cpu time over interval times cores
      6'd22: w = mk_uword(OP_LOAD, J_NEXT, A_IVL, B_CORES, CNT_CORES, '0, PC_IDLE);
      6'd23: w = mk_uword(OP_MUL, J_LOOP, A_IVL, B_CORES, CNT_NONE, '0, 6'd23);
      6'd24: w = mk_uword(OP_MVD, J_NEXT, A_IVL, B_CORES, CNT_NONE, '0, PC_IDLE);
      6'd25: w = mk_uword(OP_LOAD, J_NEXT, A_CPU, B_PCT_FULL, CNT_PCT, '0, PC_IDLE);
      6'd26: w = mk_uword(OP_MUL, J_LOOP, A_CPU, B_PCT_FULL, CNT_DIV, '0, 6'd26);
      6'd27: w = mk_uword(OP_DIV, J_LOOP, A_CPU, B_PCT_FULL, CNT_NONE, '0, 6'd27);
      6'd28: w = mk_uword(OP_STO, J_NEXT, A_CPU, B_PCT_FULL, CNT_NONE, RES_CPU, PC_IDLE);
      // cache misses over references
      6'd29: w = mk_uword(OP_LOAD, J_NEXT, A_CACHE_REF, B_ONE, CNT_ONE, '0, PC_IDLE);
      6'd30: w = mk_uword(OP_MUL, J_LOOP, A_CACHE_REF, B_ONE, CNT_NONE, '0, 6'd30);
      6'd31: w = mk_uword(OP_MVD, J_NEXT, A_CACHE_REF, B_ONE, CNT_NONE, '0, PC_IDLE);
      6'd32: w = mk_uword(OP_LOAD, J_NEXT, A_CACHE_MISS, B_PCT_FULL, CNT_PCT, '0, PC_IDLE);
      6'd33: w = mk_uword(OP_MUL, J_LOOP, A_CACHE_MISS, B_PCT_FULL, CNT_DIV, '0, 6'd33);
      6'd34: w = mk_uword(OP_DIV, J_LOOP, A_CACHE_MISS, B_PCT_FULL, CNT_NONE, '0, 6'd34);
      6'd35: w = mk_uword(OP_STO, J_NEXT, A_CACHE_MISS, B_PCT_FULL, CNT_NONE, RES_CACHE,
                          PC_IDLE);
      6'd36: w = mk_uword(OP_EMIT, J_WAIT_OUT, A_IVL, B_ONE, CNT_NONE, '0, PC_IDLE);
      default: w = mk_uword(OP_IDLE, J_WAIT_OUT, A_IVL, B_ONE, CNT_NONE, '0, PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/uea_accum.sv -----
// configuration registers and per-kind event totals
`timescale 1ns / 1ps

module uea_accum import uea_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ev_valid_i,
  input  event_t                ev_i,
  input  logic                  clear_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output totals_t               tot_o,
  output cfg_t                  cfg_o
);

  totals_t tot_q, tot_d;
  cfg_t    cfg_q, cfg_d;

  always_comb begin
    tot_d = tot_q;
    if (clear_i) begin
      tot_d = '0;
    end else if (ev_valid_i) begin
      case (ev_i.kind)
        KIND_TX_BYTES, KIND_RX_BYTES: tot_d.net_byte = tot_q.net_byte + TOT_W'(ev_i.amount);
        KIND_TX_LAT, KIND_RX_LAT:     tot_d.net_lat  = tot_q.net_lat + TOT_W'(ev_i.amount);
        KIND_BLOCK:                   tot_d.disk     = tot_q.disk + TOT_W'(ev_i.svc);
        KIND_SCHED:                   tot_d.cpu      = tot_q.cpu + TOT_W'(ev_i.amount);
        KIND_CACHE: begin
          if (ev_i.is_miss) begin
            tot_d.cache_miss = tot_q.cache_miss + TOT_W'(ev_i.amount);
          end else begin
            tot_d.cache_ref = tot_q.cache_ref + TOT_W'(ev_i.amount);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NIC_LINE_RATE: cfg_d.rate  = cfg_data_i[RATE_W-1:0];
        REG_CORE_COUNT:    cfg_d.cores = cfg_data_i[CORES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      cfg_q <= CFG_RESET;
    end else begin
      tot_q <= tot_d;
      cfg_q <= cfg_d;
    end
  end

  assign tot_o = tot_q;
  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/uea_dp.sv -----
// shift-add multiplier and restoring divider driven by the microcode word
`timescale 1ns / 1ps

module uea_dp import uea_pkg::*; (
  input  logic             clk_i,
  input  logic             start_i,
  input  logic [IVL_W-1:0] ivl_i,
  input  uword_t           uword_i,
  input  totals_t          tot_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  localparam logic [MB_W-1:0] MB_ONE = MB_W'(1);

  logic [IVL_W-1:0] ivl_q;
  logic [MUL_W-1:0] acc_a_q;
  logic [MUL_W-1:0] prod_q;
  logic [MB_W-1:0]  mulb_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic             dzero_q;
  res_t             res_q;

  logic [MUL_W-1:0] a_src;
  logic [MB_W-1:0]  b_src;
  logic [MUL_W-1:0] dsh_ext;
  logic [MUL_W-1:0] diff;
  logic             ge;
  logic [PCT_W-1:0] sto_val;

  always_comb begin
    case (uword_i.a_sel)
      A_NET_BYTE:   a_src = MUL_W'(tot_i.net_byte);
      A_NET_LAT:    a_src = MUL_W'(tot_i.net_lat);
      A_DISK:       a_src = MUL_W'(tot_i.disk);
      A_CPU:        a_src = MUL_W'(tot_i.cpu);
      A_CACHE_MISS: a_src = MUL_W'(tot_i.cache_miss);
      A_CACHE_REF:  a_src = MUL_W'(tot_i.cache_ref);
      A_IVL:        a_src = MUL_W'(ivl_q);
      default:      a_src = '0;
    endcase
  end

  always_comb begin
    case (uword_i.b_sel)
      B_NS_PCT:   b_src = NS_PCT_SCALE;
      B_PCT_FULL: b_src = MB_W'(PCT_FULL);
      B_RATE:     b_src = (cfg_i.rate != '0) ? MB_W'(cfg_i.rate) : MB_W'(DEFAULT_LINE_RATE);
      B_CORES:    b_src = (cfg_i.cores != '0) ? MB_W'(cfg_i.cores) : MB_ONE;
      B_ONE:      b_src = MB_ONE;
      default:    b_src = MB_ONE;
    endcase
  end

  assign dsh_ext = MUL_W'(dsh_q);
  assign ge      = (prod_q >= dsh_ext);
  assign diff    = prod_q - dsh_ext;
  assign sto_val = dzero_q ? '0 :
                   (quo_q > QUO_W'(PCT_FULL)) ? PCT_FULL : quo_q[PCT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ivl_q <= ivl_i;
    end
    case (uword_i.op)
      OP_LOAD: begin
        acc_a_q <= a_src;
        mulb_q  <= b_src;
        prod_q  <= '0;
      end
      OP_MUL: begin
        if (mulb_q[0]) begin
          prod_q <= prod_q + acc_a_q;
        end
        acc_a_q <= acc_a_q << 1;
        mulb_q  <= mulb_q >> 1;
      end
      OP_MVD: begin
        dsh_q   <= {prod_q[DEN_W-1:0], {(QUO_W-1){1'b0}}};
        dzero_q <= (prod_q[DEN_W-1:0] == '0);
        quo_q   <= '0;
      end
      OP_DIV: begin
        if (ge) begin
          prod_q <= diff;
        end
        quo_q <= {quo_q[QUO_W-2:0], ge};
        dsh_q <= dsh_q >> 1;
      end
      OP_STO: res_q[uword_i.ridx] <= sto_val;
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/uea_seq.sv -----
// microcode sequencer: program counter, step counter and jump logic
`timescale 1ns / 1ps

`include "utilization_event_accumulator_macros.svh"

module uea_seq import uea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      out_free_i,
  output uword_t    uword_o,
  output seq_stat_t stat_o
);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  uword_t           word;

  assign word = ucode_rom(pc_q);

  always_comb begin
    pc_d  = pc_q + PC_W'(1);
    cnt_d = word.cnt;
    case (word.jmp)
      J_NEXT: ;
      J_LOOP: begin
        if (cnt_q != CNT_ONE) begin
          pc_d  = word.target;
          cnt_d = cnt_q - CNT_ONE;
        end
      end
      J_WAIT_START: begin
        if (!start_i) begin
          pc_d  = pc_q;
          cnt_d = cnt_q;
        end
      end
      J_WAIT_OUT: begin
        if (out_free_i) begin
          pc_d = word.target;
        end else begin
          pc_d  = pc_q;
          cnt_d = cnt_q;
        end
      end
      default: begin
        pc_d  = PC_IDLE;
        cnt_d = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_IDLE;
      cnt_q <= CNT_NONE;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign uword_o     = word;
  assign stat_o.busy = (pc_q != PC_IDLE);
  assign stat_o.emit = (word.op == OP_EMIT) && out_free_i;

  `UEA_ASSERT_IMP(a_loop_cnt, word.jmp == J_LOOP, cnt_q != CNT_NONE)
  `UEA_ASSERT_IMP(a_pc_range, 1'b1, pc_q <= PC_EMIT)
  `UEA_ASSERT_IMP(a_start_idle, start_i, (pc_q == PC_IDLE) && (word.op == OP_IDLE))
  `UEA_ASSERT_NXT(a_emit_idle, stat_o.emit, (pc_q == PC_IDLE) && !stat_o.busy)

endmodule

// ----- rtl/core/utilization_event_accumulator.sv -----
// top level of the utilization event accumulator.
// Profiling events (req_type 0) are taken one per clock while the block is idle and add to
// per-kind 64-bit totals; events with well_formed low or an unknown kind change nothing.
// A report request (req_type 1) holds in_stall_o high while a microcoded sequencer works out
// the five percentages with a one-bit-per-cycle shift-add multiplier and a one-bit-per-cycle
// restoring divider. The multiplier walks 40 and 44 bits for throughput, 1 and 14 for stack
// and disk, 11 and 14 for cpu and 1 and 14 for cache, and each figure adds 15 divide steps
// and 4 control steps; the sequencer waits at the emit step while an earlier result is still
// stalled at the output. The totals clear when the result is loaded into the output register.
// Configuration writes are always ready.
`timescale 1ns / 1ps

module utilization_event_accumulator import uea_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [KIND_W-1:0]     event_kind_i,
  input  logic [AMT_W-1:0]      event_amount_i,
  input  logic [AMT_W-1:0]      service_time_i,
  input  logic                  is_miss_i,
  input  logic                  well_formed_i,
  input  logic [IVL_W-1:0]      interval_ns_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PCT_W-1:0]      net_throughput_pct_o,
  output logic [PCT_W-1:0]      net_stack_pct_o,
  output logic [PCT_W-1:0]      disk_busy_pct_o,
  output logic [PCT_W-1:0]      cpu_busy_pct_o,
  output logic [PCT_W-1:0]      cache_miss_pct_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  seq_stat_t stat;
  uword_t    uword;
  totals_t   tot;
  cfg_t      cfg;
  event_t    ev;
  res_t      res;
  res_t      out_res_q;
  logic      out_valid_q;
  logic      in_acc;
  logic      start;
  logic      ev_valid;
  logic      out_free;

  assign in_stall_o  = stat.busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign start       = in_acc && req_type_i;
  assign ev_valid    = in_acc && !req_type_i && well_formed_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign ev.kind    = event_kind_i;
  assign ev.amount  = event_amount_i;
  assign ev.svc     = service_time_i;
  assign ev.is_miss = is_miss_i;

  uea_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev),
    .clear_i     (stat.emit),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tot_o       (tot),
    .cfg_o       (cfg)
  );

  uea_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .uword_o    (uword),
    .stat_o     (stat)
  );

  uea_dp u_dp (
    .clk_i   (clk_i),
    .start_i (start),
    .ivl_i   (interval_ns_i),
    .uword_i (uword),
    .tot_i   (tot),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= stat.emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.emit) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign net_throughput_pct_o = out_res_q[RES_NET_TPUT];
  assign net_stack_pct_o      = out_res_q[RES_NET_STACK];
  assign disk_busy_pct_o      = out_res_q[RES_DISK];
  assign cpu_busy_pct_o       = out_res_q[RES_CPU];
  assign cache_miss_pct_o     = out_res_q[RES_CACHE];

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the utilization event accumulator
`timescale 1ns / 1ps

module tb;
  import uea_pkg::*;

  localparam logic REQ_EVENT  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [KIND_W-1:0]    KIND_UNKNOWN = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int DRAIN_CYCLES    = 260;
  localparam int CYCLE_LIMIT     = 2000000;

  typedef struct packed {
    logic              req;
    logic [KIND_W-1:0] kind;
    logic [AMT_W-1:0]  amount;
    logic [AMT_W-1:0]  svc;
    logic              miss;
    logic              ok;
    logic [IVL_W-1:0]  ivl;
  } request_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  req_type_i     = 1'b0;
  logic [KIND_W-1:0]     event_kind_i   = '0;
  logic [AMT_W-1:0]      event_amount_i = '0;
  logic [AMT_W-1:0]      service_time_i = '0;
  logic                  is_miss_i      = 1'b0;
  logic                  well_formed_i  = 1'b0;
  logic [IVL_W-1:0]      interval_ns_i  = '0;
  logic                  out_stall_i    = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  cfg_ready_o;
  logic [PCT_W-1:0]      net_throughput_pct_o;
  logic [PCT_W-1:0]      net_stack_pct_o;
  logic [PCT_W-1:0]      disk_busy_pct_o;
  logic [PCT_W-1:0]      cpu_busy_pct_o;
  logic [PCT_W-1:0]      cache_miss_pct_o;

  // accumulator and register state of the predictor
  logic [TOT_W-1:0]   net_bytes_sum = '0;
  logic [TOT_W-1:0]   net_lat_sum   = '0;
  logic [TOT_W-1:0]   disk_sum      = '0;
  logic [TOT_W-1:0]   cpu_sum       = '0;
  logic [TOT_W-1:0]   ref_sum       = '0;
  logic [TOT_W-1:0]   miss_sum      = '0;
  logic [RATE_W-1:0]  line_rate     = CFG_RESET.rate;
  logic [CORES_W-1:0] core_cnt      = CFG_RESET.cores;

  request_t request_q [$];
  res_t     expected_q [$];

  string field_name [NRES] = '{"net_throughput_pct", "net_stack_pct", "disk_busy_pct",
                               "cpu_busy_pct", "cache_miss_pct"};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_errors      = 0;
  int n_requests    = 0;
  int n_reports     = 0;
  int cycle_count   = 0;

  utilization_event_accumulator u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .req_type_i           (req_type_i),
    .event_kind_i         (event_kind_i),
    .event_amount_i       (event_amount_i),
    .service_time_i       (service_time_i),
    .is_miss_i            (is_miss_i),
    .well_formed_i        (well_formed_i),
    .interval_ns_i        (interval_ns_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .net_throughput_pct_o (net_throughput_pct_o),
    .net_stack_pct_o      (net_stack_pct_o),
    .disk_busy_pct_o      (disk_busy_pct_o),
    .cpu_busy_pct_o       (cpu_busy_pct_o),
    .cache_miss_pct_o     (cache_miss_pct_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // truncated quotient of num * mul over d1 * d2, saturated at full scale
  function automatic logic [PCT_W-1:0] utilization(logic [63:0] num, logic [63:0] mul,
                                                   logic [63:0] d1, logic [63:0] d2);
    logic [127:0] prod;
    logic [127:0] den;
    logic [127:0] quo;
    if (d1 == '0 || d2 == '0) return '0;
    prod = {64'd0, num} * {64'd0, mul};
    den  = {64'd0, d1} * {64'd0, d2};
    quo  = prod / den;
    return (quo > 128'(PCT_FULL)) ? PCT_FULL : quo[PCT_W-1:0];
  endfunction

  function automatic request_t event_req(logic [KIND_W-1:0] kind, logic [AMT_W-1:0] amount,
                                         logic [AMT_W-1:0] svc, logic miss, logic ok);
    request_t r;
    r.req    = REQ_EVENT;
    r.kind   = kind;
    r.amount = amount;
    r.svc    = svc;
    r.miss   = miss;
    r.ok     = ok;
    r.ivl    = IVL_W'({$urandom, $urandom});
    return r;
  endfunction

  function automatic request_t report_req(logic [IVL_W-1:0] ivl);
    request_t r;
    r.req    = REQ_REPORT;
    r.kind   = KIND_W'($urandom_range(0, 7));
    r.amount = $urandom;
    r.svc    = $urandom;
    r.miss   = 1'($urandom_range(0, 1));
    r.ok     = 1'($urandom_range(0, 1));
    r.ivl    = ivl;
    return r;
  endfunction

  function automatic request_t rand_event();
    return event_req(KIND_W'($urandom_range(0, 6)), $urandom >> $urandom_range(0, 31),
                     $urandom >> $urandom_range(0, 31), 1'($urandom_range(0, 1)), 1'b1);
  endfunction

  function automatic logic [IVL_W-1:0] rand_interval();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return raw[IVL_W-1:0] >> $urandom_range(0, IVL_W - 1);
    endcase
  endfunction

  // leaves cfg_valid_i high so that writes can follow back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_NIC_LINE_RATE: line_rate = data[RATE_W-1:0];
      REG_CORE_COUNT:    core_cnt  = data[CORES_W-1:0];
      default: ;
    endcase
  endtask

  // checked between edges so that a request popped at the edge is seen as in flight
  task automatic settle();
    while (request_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_requests
    request_t         nxt;
    res_t             fig;
    logic [RATE_W-1:0]  rate;
    logic [CORES_W-1:0] cores;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        n_requests++;
        if (req_type_i == REQ_EVENT) begin
          if (well_formed_i) begin
            case (event_kind_i)
              KIND_TX_BYTES, KIND_RX_BYTES: net_bytes_sum += TOT_W'(event_amount_i);
              KIND_TX_LAT, KIND_RX_LAT:     net_lat_sum   += TOT_W'(event_amount_i);
              KIND_BLOCK:                   disk_sum      += TOT_W'(service_time_i);
              KIND_SCHED:                   cpu_sum       += TOT_W'(event_amount_i);
              KIND_CACHE: begin
                if (is_miss_i) miss_sum += TOT_W'(event_amount_i);
                else ref_sum += TOT_W'(event_amount_i);
              end
              default: ;
            endcase
          end
        end else begin
          rate  = (line_rate != '0) ? line_rate : DEFAULT_LINE_RATE;
          cores = (core_cnt != '0) ? core_cnt : CORES_W'(1);
          fig[RES_NET_TPUT]  = utilization(net_bytes_sum, 64'(NS_PCT_SCALE),
                                           64'(interval_ns_i), 64'(rate));
          fig[RES_NET_STACK] = utilization(net_lat_sum, 64'(PCT_FULL), 64'(interval_ns_i),
                                           64'd1);
          fig[RES_DISK]      = utilization(disk_sum, 64'(PCT_FULL), 64'(interval_ns_i),
                                           64'd1);
          fig[RES_CPU]       = utilization(cpu_sum, 64'(PCT_FULL), 64'(interval_ns_i),
                                           64'(cores));
          fig[RES_CACHE]     = utilization(miss_sum, 64'(PCT_FULL), ref_sum, 64'd1);
          expected_q.push_back(fig);
          net_bytes_sum = '0;
          net_lat_sum   = '0;
          disk_sum      = '0;
          cpu_sum       = '0;
          ref_sum       = '0;
          miss_sum      = '0;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid_i     <= 1'b1;
          req_type_i     <= nxt.req;
          event_kind_i   <= nxt.kind;
          event_amount_i <= nxt.amount;
          service_time_i <= nxt.svc;
          is_miss_i      <= nxt.miss;
          well_formed_i  <= nxt.ok;
          interval_ns_i  <= nxt.ivl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got[RES_NET_TPUT]  = net_throughput_pct_o;
        got[RES_NET_STACK] = net_stack_pct_o;
        got[RES_DISK]      = disk_busy_pct_o;
        got[RES_CPU]       = cpu_busy_pct_o;
        got[RES_CACHE]     = cache_miss_pct_o;
        if (expected_q.size() == 0) begin
          $error("result with no report pending");
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          n_reports++;
          for (int f = 0; f < NRES; f++) begin
            if (got[f] != want[f]) begin
              $error("%s: expected %0d, actual %0d", field_name[f], want[f], got[f]);
              n_errors++;
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    request_t r;
    int       useful;
    int       burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 83;

    // empty interval, no references
    request_q.push_back(report_req(40'd1000));
    request_q.push_back(event_req(KIND_TX_BYTES, 32'd62500000, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_RX_BYTES, 32'd31250000, '1, 1'b1, 1'b1));
    request_q.push_back(event_req(KIND_TX_LAT, 32'd250000000, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_RX_LAT, 32'd250000000, '0, 1'b1, 1'b1));
    request_q.push_back(event_req(KIND_BLOCK, '1, 32'd333333333, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_SCHED, 32'd999999999, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_CACHE, 32'd3, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_CACHE, 32'd1, '0, 1'b1, 1'b1));
    // malformed record and unknown kind change nothing
    request_q.push_back(event_req(KIND_TX_BYTES, '1, '1, 1'b0, 1'b0));
    request_q.push_back(event_req(KIND_UNKNOWN, '1, '1, 1'b1, 1'b1));
    request_q.push_back(report_req(40'd1000000000));
    // saturated amounts, then a zero interval
    request_q.push_back(event_req(KIND_TX_BYTES, '1, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_RX_BYTES, '1, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_RX_LAT, '1, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_BLOCK, '0, '1, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_SCHED, '1, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_CACHE, '1, '0, 1'b1, 1'b1));
    request_q.push_back(report_req('0));
    request_q.push_back(event_req(KIND_TX_LAT, 32'd1, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_CACHE, '1, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_CACHE, '1, '0, 1'b1, 1'b1));
    request_q.push_back(report_req('1));
    // tiny interval pushes the cpu and throughput figures past full scale
    request_q.push_back(event_req(KIND_SCHED, 32'd5, '0, 1'b0, 1'b1));
    request_q.push_back(event_req(KIND_TX_BYTES, 32'd1, '0, 1'b0, 1'b1));
    request_q.push_back(report_req(40'd1));
    r = report_req(40'd100);
    r.kind   = '1;
    r.amount = '1;
    r.svc    = '1;
    r.miss   = 1'b1;
    r.ok     = 1'b1;
    request_q.push_back(r);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_NIC_LINE_RATE, 40'd1);
          write_reg(REG_CORE_COUNT, 40'd0);
          write_reg(REG_SPARE_2, '1);
        end
        1: begin
          write_reg(REG_NIC_LINE_RATE, '1);
          write_reg(REG_CORE_COUNT, 40'd2047);
        end
        2: begin
          write_reg(REG_NIC_LINE_RATE, DEFAULT_LINE_RATE);
          write_reg(REG_CORE_COUNT, 40'd1024);
        end
        3: begin
          write_reg(REG_NIC_LINE_RATE, CFG_DATA_W'({$urandom, $urandom}) >>
                                       $urandom_range(0, RATE_W - 1));
          write_reg(REG_CORE_COUNT, CFG_DATA_W'($urandom_range(1, 64)));
          write_reg(REG_SPARE_3, CFG_DATA_W'({$urandom, $urandom}));
        end
        4: begin
          write_reg(REG_NIC_LINE_RATE, '0);
          write_reg(REG_CORE_COUNT, 40'd1);
        end
        default: begin
          write_reg(REG_NIC_LINE_RATE, CFG_DATA_W'({$urandom, $urandom}) >>
                                       $urandom_range(0, RATE_W - 1));
          // upper data bits above the core field are dropped
          write_reg(REG_CORE_COUNT, CFG_DATA_W'({$urandom, $urandom}));
        end
      endcase
      cfg_valid_i <= 1'b0;

      if (p < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 83;
      end else if (p < 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // bursts of events closed by a report, with some ignored records mixed in
      useful = 0;
      while (useful < ITEMS_PER_PHASE) begin
        burst = $urandom_range(0, 12);
        repeat (burst) begin
          r = rand_event();
          if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) r.ok = 1'b0;
            else r.kind = KIND_UNKNOWN;
          end else begin
            useful++;
          end
          request_q.push_back(r);
        end
        request_q.push_back(report_req(rand_interval()));
        useful++;
      end
      settle();
    end

    $display("%0d requests accepted, %0d reports checked field by field", n_requests,
             n_reports);
    $display("register settings: reset values plus %0d written phases, idling varied",
             NUM_PHASES);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
